### sv/line_substring_matcher_defines.svh
// Assertion macros shared by the line substring matcher modules.
`ifndef LINE_SUBSTRING_MATCHER_DEFINES_SVH
`define LINE_SUBSTRING_MATCHER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define LSM_ASSERT_SAME(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define LSM_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

### sv/lsm_pkg.sv
// Shared types, constants and helpers for the line substring matcher.
package lsm_pkg;

  localparam int LEN_W         = 5;
  localparam int CHAR_W        = 8;
  localparam int CFG_INDEX_W   = 8;
  localparam int CFG_DATA_W    = 64;
  localparam int PATTERN_BYTES = 16;
  localparam int PATTERN_W     = PATTERN_BYTES * CHAR_W;
  localparam int OUT_NUMBER_W  = 32;
  localparam int COUNT_WIDE_W  = 64;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CHAR_W-1:0]      char_t;

  localparam cfg_index_t REG_PATTERN_LOW    = 8'd0;
  localparam cfg_index_t REG_PATTERN_HIGH   = 8'd1;
  localparam cfg_index_t REG_PATTERN_LENGTH = 8'd2;
  localparam cfg_index_t REG_IGNORE_CASE    = 8'd3;

  localparam char_t NEWLINE_BYTE = 8'd10;
  localparam char_t UPPER_A      = 8'h41;
  localparam char_t UPPER_Z      = 8'h5A;
  localparam char_t CASE_OFFSET  = 8'h20;

  localparam logic [LEN_W-1:0] RESET_LENGTH = 5'd1;

  typedef struct packed {
    logic [PATTERN_W-1:0] pattern;
    logic [LEN_W-1:0]     length;
    logic                 ignore_case;
  } cfg_t;

  function automatic char_t fold_char(input char_t b, input logic ic);
    char_t r;
    r = b;
    if (ic && b >= UPPER_A && b <= UPPER_Z) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

### sv/lsm_config.sv
// Configuration registers of the line substring matcher.
module lsm_config #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [lsm_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [lsm_pkg::CFG_DATA_W-1:0]   wr_data,
  output lsm_pkg::cfg_t                    cfg
);

  logic [lsm_pkg::CFG_DATA_W-1:0] pat_low_r;
  logic [lsm_pkg::CFG_DATA_W-1:0] pat_high_r;
  logic [lsm_pkg::LEN_W-1:0]      len_r;
  logic                           ic_r;
  logic [lsm_pkg::LEN_W-1:0]      len_act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      len_r      <= lsm_pkg::RESET_LENGTH;
      ic_r       <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        lsm_pkg::REG_PATTERN_LOW:    pat_low_r  <= wr_data;
        lsm_pkg::REG_PATTERN_HIGH:   pat_high_r <= wr_data;
        lsm_pkg::REG_PATTERN_LENGTH: len_r      <= wr_data[lsm_pkg::LEN_W-1:0];
        lsm_pkg::REG_IGNORE_CASE:    ic_r       <= wr_data[0];
        default: ;
      endcase
    end
  end

  // A zero length acts as one byte; anything above the window depth is clamped.
  always_comb begin
    len_act = len_r;
    if (len_r == '0) begin
      len_act = lsm_pkg::RESET_LENGTH;
    end else if (len_r > lsm_pkg::LEN_W'(MAX_PATTERN)) begin
      len_act = lsm_pkg::LEN_W'(MAX_PATTERN);
    end
  end

  assign cfg.pattern     = {pat_high_r, pat_low_r};
  assign cfg.length      = len_act;
  assign cfg.ignore_case = ic_r;

endmodule

### sv/lsm_window_match.sv
// Byte window of the current line and the parallel pattern compare.
`include "line_substring_matcher_defines.svh"

module lsm_window_match #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 clear,
  input  lsm_pkg::char_t       char_in,
  input  lsm_pkg::cfg_t        cfg,
  output logic                 match
);

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  lsm_pkg::char_t    win_r   [MAX_PATTERN];
  lsm_pkg::char_t    win_nxt [MAX_PATTERN];
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;

  // Entry 0 holds the newest byte of the line.
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      win_nxt[k] = (k == 0) ? char_in : win_r[(k == 0) ? 0 : k - 1];
    end
    fill_nxt = (fill_r < FILL_W'(MAX_PATTERN)) ? fill_r + 1'b1 : fill_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_r[k] <= '0;
      end
    end else if (clear) begin
      fill_r <= '0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_r[k] <= '0;
      end
    end else if (step) begin
      fill_r <= fill_nxt;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

  // Pattern byte i lines up with the window entry length-1-i.
  always_comb begin
    logic [lsm_pkg::LEN_W-1:0] idx;
    logic                      all_eq;
    all_eq = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      idx = cfg.length - lsm_pkg::LEN_W'(i) - 1'b1;
      if (lsm_pkg::LEN_W'(i) < cfg.length) begin
        if (lsm_pkg::fold_char(win_nxt[idx[IDX_W-1:0]], cfg.ignore_case) !=
            lsm_pkg::fold_char(cfg.pattern[i*lsm_pkg::CHAR_W +: lsm_pkg::CHAR_W],
                               cfg.ignore_case)) begin
          all_eq = 1'b0;
        end
      end
    end
    match = all_eq && (lsm_pkg::LEN_W'(fill_nxt) >= cfg.length);
  end

  `LSM_ASSERT_SAME(a_fill_bound, 1'b1, fill_r <= FILL_W'(MAX_PATTERN), "fill beyond depth")
  `LSM_ASSERT_NEXT(a_clear_empties, clear, fill_r == '0, "window not cleared at line end")
  `LSM_ASSERT_NEXT(a_step_grows, step && !clear && fill_r < FILL_W'(MAX_PATTERN),
                   fill_r == $past(fill_r) + 1'b1, "fill did not advance")

endmodule

### sv/line_substring_matcher.sv
// Top level of the line substring matcher: handshakes, line counter and result register.
// Latency: a newline item's result is offered the cycle after the newline is accepted.
// Throughput: one item per cycle; the only stall is a result left waiting in the output
// register while the next item arrives, set by that single result register.
// Reset (rst_n low, synchronous): empty window, no hit, line counter zero, no result,
// pattern zero, pattern length one, exact compare.
`include "line_substring_matcher_defines.svh"

module line_substring_matcher #(
  parameter int MAX_PATTERN     = 16,
  parameter int LINE_COUNT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lsm_pkg::CHAR_W-1:0]          in_char_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lsm_pkg::OUT_NUMBER_W-1:0]    out_line_number,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lsm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lsm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  lsm_pkg::cfg_t                       cfg;
  logic                                in_acc;
  logic                                is_nl;
  logic                                step;
  logic                                clear;
  logic                                match;
  logic                                hit_r;
  logic [LINE_COUNT_BITS-1:0]          cnt_r;
  logic [LINE_COUNT_BITS-1:0]          cnt_nxt;
  logic [lsm_pkg::COUNT_WIDE_W-1:0]    cnt_wide;
  logic                                out_valid_r;
  logic [lsm_pkg::OUT_NUMBER_W-1:0]    line_number_r;

  // Configuration writes are taken unchecked; user writes only while the block is idle.
  assign cfg_ready = 1'b1;

  lsm_config #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_config (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // An item can enter whenever the result register is free or is being drained in the
  // same cycle, so the input stalls only while a result waits and the receiver holds off.
  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;
  assign is_nl    = (in_char_in == lsm_pkg::NEWLINE_BYTE);
  assign step     = in_acc && !is_nl;
  assign clear    = in_acc && is_nl;

  lsm_window_match #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .clear   (clear),
    .char_in (in_char_in),
    .cfg     (cfg),
    .match   (match)
  );

  // The line counter holds once it reaches its maximum; the reported number is its low
  // bits, zero-extended when the counter is narrower than the output.
  assign cnt_nxt  = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
  assign cnt_wide = lsm_pkg::COUNT_WIDE_W'(cnt_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
      cnt_r <= '0;
    end else if (clear) begin
      hit_r <= 1'b0;
      cnt_r <= cnt_nxt;
    end else if (step && match) begin
      hit_r <= 1'b1;
    end
  end

  // Result register: loaded by a newline that ends a line holding the pattern.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (clear) begin
      out_valid_r <= hit_r;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      line_number_r <= cnt_wide[lsm_pkg::OUT_NUMBER_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_line_number = line_number_r;

  `LSM_ASSERT_NEXT(a_hit_gives_result, clear && hit_r, out_valid_r, "hit line gave no result")
  `LSM_ASSERT_NEXT(a_byte_no_result, step, !out_valid_r, "ordinary byte produced a result")
  `LSM_ASSERT_NEXT(a_hit_cleared, clear, !hit_r, "hit flag survived line end")
  `LSM_ASSERT_NEXT(a_count_saturates, cnt_r == '1, cnt_r == '1, "line counter wrapped")

endmodule

### test/lsm_line_checker.sv
// Line substring matcher checker: mirrors the registers, predicts hit lines, compares results.
module lsm_line_checker #(
  parameter int MAX_PATTERN     = 16,
  parameter int LINE_COUNT_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [lsm_pkg::CHAR_W-1:0]       in_char_in,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [lsm_pkg::OUT_NUMBER_W-1:0] out_line_number,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [lsm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lsm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               fail_count,
  output int                               due_count
);

  logic [lsm_pkg::CFG_DATA_W-1:0]   pat_low;
  logic [lsm_pkg::CFG_DATA_W-1:0]   pat_high;
  logic [lsm_pkg::LEN_W-1:0]        len_code;
  logic                             fold_on;

  lsm_pkg::char_t                   recent [MAX_PATTERN];
  int                               line_fill;
  logic                             line_hit;
  logic [LINE_COUNT_BITS-1:0]       lines_done;
  logic [lsm_pkg::OUT_NUMBER_W-1:0] due_line_numbers [$];

  function automatic lsm_pkg::char_t folded(input lsm_pkg::char_t b);
    if (fold_on && b >= lsm_pkg::UPPER_A && b <= lsm_pkg::UPPER_Z) begin
      return b | lsm_pkg::CASE_OFFSET;
    end
    return b;
  endfunction

  // Compares the newest bytes of the line, oldest first, with the pattern.
  function automatic logic window_matches();
    logic [lsm_pkg::PATTERN_W-1:0] pat;
    int                            n;
    n = (len_code == 0) ? 1 : (len_code > MAX_PATTERN) ? MAX_PATTERN : int'(len_code);
    if (line_fill < n) begin
      return 1'b0;
    end
    pat = {pat_high, pat_low};
    for (int i = 0; i < n; i++) begin
      if (folded(recent[n-1-i]) !=
          folded(pat[i*lsm_pkg::CHAR_W +: lsm_pkg::CHAR_W])) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic scan_char(input lsm_pkg::char_t b);
    if (b == lsm_pkg::NEWLINE_BYTE) begin
      if (lines_done != '1) begin
        lines_done = lines_done + 1'b1;
      end
      if (line_hit) begin
        due_line_numbers.push_back(lsm_pkg::OUT_NUMBER_W'(lines_done));
      end
      line_fill = 0;
      line_hit  = 1'b0;
      foreach (recent[k]) recent[k] = '0;
    end else begin
      for (int k = MAX_PATTERN - 1; k > 0; k--) begin
        recent[k] = recent[k-1];
      end
      recent[0] = b;
      if (line_fill < MAX_PATTERN) begin
        line_fill++;
      end
      if (window_matches()) begin
        line_hit = 1'b1;
      end
    end
  endtask

  // Sampled between edges, where every handshake signal has settled.
  always @(negedge clk) begin
    logic [lsm_pkg::OUT_NUMBER_W-1:0] want;
    if (!rst_n) begin
      pat_low    = '0;
      pat_high   = '0;
      len_code   = lsm_pkg::RESET_LENGTH;
      fold_on    = 1'b0;
      foreach (recent[k]) recent[k] = '0;
      line_fill  = 0;
      line_hit   = 1'b0;
      lines_done = '0;
      due_line_numbers.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lsm_pkg::REG_PATTERN_LOW:    pat_low  = cfg_data;
          lsm_pkg::REG_PATTERN_HIGH:   pat_high = cfg_data;
          lsm_pkg::REG_PATTERN_LENGTH: len_code = cfg_data[lsm_pkg::LEN_W-1:0];
          lsm_pkg::REG_IGNORE_CASE:    fold_on  = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (due_line_numbers.size() == 0) begin
          fail_count++;
          $display("%0t: line_number expected none, got %0d", $time, out_line_number);
        end else begin
          want = due_line_numbers.pop_front();
          if (want !== out_line_number) begin
            fail_count++;
            $display("%0t: line_number expected %0d, got %0d", $time, want, out_line_number);
          end
        end
      end
      if (in_valid && in_ready) begin
        scan_char(in_char_in);
      end
    end
    due_count = due_line_numbers.size();
  end

endmodule

### test/tb_line_substring_matcher.sv
// Testbench top for the line substring matcher: clock, reset, text, result stalls, verdict.
module tb_line_substring_matcher;

  // Number of registers the block decodes; anything at or above this index is a stray write.
  localparam int REG_COUNT   = 4;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 150;

  typedef enum int {PAT_ANY, PAT_LETTERS, PAT_ONES, PAT_ZEROS} pat_fill_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_ready;
  lsm_pkg::char_t                   in_char_in;
  logic                             out_valid;
  logic                             out_ready;
  logic [lsm_pkg::OUT_NUMBER_W-1:0] out_line_number;
  logic                             cfg_valid;
  logic                             cfg_ready;
  lsm_pkg::cfg_index_t              cfg_index;
  logic [lsm_pkg::CFG_DATA_W-1:0]   cfg_data;
  int                               fail_count;
  int                               due_count;

  // Pattern as last loaded, kept only to shape the text; prediction lives in the checker.
  lsm_pkg::char_t pat [lsm_pkg::PATTERN_BYTES];
  int             eff_len;
  bit             fold_on;
  int             phase_items;

  line_substring_matcher u_dut (.*);

  lsm_line_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs a handshake.
  initial begin
    #4000000;
    $display("[line_substring_matcher] ERROR");
    $finish;
  end

  // Sender gaps: mostly back to back, sometimes short, now and then a long pause.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 30);
  endfunction

  // Filler length around the pattern; long spans push lines well past the window depth.
  function automatic int span();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 30);
  endfunction

  function automatic lsm_pkg::char_t any_letter();
    lsm_pkg::char_t c;
    c = lsm_pkg::UPPER_A + lsm_pkg::char_t'($urandom_range(0, 25));
    if ($urandom_range(0, 1) == 1) begin
      c = c | lsm_pkg::CASE_OFFSET;
    end
    return c;
  endfunction

  // When case folding is on, letters are sent in random case so that folding is exercised.
  function automatic lsm_pkg::char_t vary_case(input lsm_pkg::char_t c);
    lsm_pkg::char_t l;
    l = c | lsm_pkg::CASE_OFFSET;
    if (fold_on && l >= (lsm_pkg::UPPER_A | lsm_pkg::CASE_OFFSET) &&
        l <= (lsm_pkg::UPPER_Z | lsm_pkg::CASE_OFFSET) &&
        $urandom_range(0, 1) == 1) begin
      return c ^ lsm_pkg::CASE_OFFSET;
    end
    return c;
  endfunction

  // Half of the filler is drawn from the pattern itself, which produces plenty of near misses.
  function automatic lsm_pkg::char_t filler();
    lsm_pkg::char_t c;
    if ($urandom_range(0, 1) == 1) begin
      return vary_case(pat[$urandom_range(0, eff_len - 1)]);
    end
    c = lsm_pkg::char_t'($urandom_range(0, 255));
    return (c == lsm_pkg::NEWLINE_BYTE) ? lsm_pkg::UPPER_A : c;
  endfunction

  // Offers one item and returns at the edge that accepts it. The caller stands at a rising edge.
  // Valid is lowered only when a gap is taken, so it is never lowered and raised in one step.
  task automatic send_char(input lsm_pkg::char_t b, input bit eager);
    int gap;
    gap = eager ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= b;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    phase_items++;
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) begin
      send_char(lsm_pkg::char_t'(s[k]), 1'b0);
    end
  endtask

  // Register writes go back to back; the caller drops cfg_valid after the last one.
  task automatic write_reg(input lsm_pkg::cfg_index_t idx,
                           input logic [lsm_pkg::CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // Stops offering text and waits until every predicted result has come out. The block gives
  // its result the cycle after a newline, and a line that ends without one gives no result.
  task automatic settle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (due_count != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic make_pattern(input pat_fill_t how);
    foreach (pat[k]) begin
      case (how)
        PAT_ONES:    pat[k] = '1;
        PAT_ZEROS:   pat[k] = '0;
        PAT_LETTERS: pat[k] = any_letter();
        default: begin
          pat[k] = lsm_pkg::char_t'($urandom_range(0, 255));
          if (pat[k] == lsm_pkg::NEWLINE_BYTE) begin
            pat[k] = lsm_pkg::UPPER_Z;
          end
        end
      endcase
    end
  endtask

  // Loads all four registers from the pattern array. Unused upper bits of the length and case
  // words carry random junk, and a stray write to an index past the register list may follow.
  task automatic load_pattern(input logic [lsm_pkg::LEN_W-1:0] len_code, input bit icase,
                              input bit stray);
    logic [lsm_pkg::CFG_DATA_W-1:0] lo;
    logic [lsm_pkg::CFG_DATA_W-1:0] hi;
    logic [lsm_pkg::CFG_DATA_W-1:0] junk;
    for (int k = 0; k < 8; k++) begin
      lo[k*lsm_pkg::CHAR_W +: lsm_pkg::CHAR_W] = pat[k];
      hi[k*lsm_pkg::CHAR_W +: lsm_pkg::CHAR_W] = pat[k+8];
    end
    junk = {$urandom, $urandom};
    write_reg(lsm_pkg::REG_PATTERN_LOW, lo);
    write_reg(lsm_pkg::REG_PATTERN_HIGH, hi);
    write_reg(lsm_pkg::REG_PATTERN_LENGTH, {junk[lsm_pkg::CFG_DATA_W-1:lsm_pkg::LEN_W], len_code});
    write_reg(lsm_pkg::REG_IGNORE_CASE, {junk[lsm_pkg::CFG_DATA_W-1:1], icase});
    if (stray) begin
      write_reg(lsm_pkg::cfg_index_t'($urandom_range(REG_COUNT, 255)), {$urandom, $urandom});
    end
    cfg_valid <= 1'b0;
    fold_on = icase;
    eff_len = (len_code == 0) ? 1 :
              (len_code > lsm_pkg::PATTERN_BYTES) ? lsm_pkg::PATTERN_BYTES : int'(len_code);
  endtask

  // One line of text. Most lines are well formed: filler, then a full, corrupted or truncated
  // copy of the pattern, more filler and a newline. Some are filler only, and a few are raw
  // noise whose stray newlines split lines anywhere.
  task automatic send_line();
    int             kind;
    int             pre;
    int             post;
    int             cut;
    int             bad;
    bit             eager;
    lsm_pkg::char_t c;
    eager = ($urandom_range(0, 3) == 0);
    kind  = $urandom_range(0, 9);
    pre   = span();
    post  = span();
    if (kind == 9) begin
      repeat ($urandom_range(1, 30)) send_char(lsm_pkg::char_t'($urandom_range(0, 255)), eager);
    end else begin
      cut = (kind == 6) ? eff_len - 1 : (kind > 6) ? 0 : eff_len;
      bad = (kind == 5) ? $urandom_range(0, eff_len - 1) : -1;
      repeat (pre) send_char(filler(), eager);
      for (int k = 0; k < cut; k++) begin
        c = vary_case(pat[k]);
        if (k == bad) begin
          c = c ^ lsm_pkg::char_t'($urandom_range(1, 255));
        end
        send_char(c, eager);
      end
      repeat (post) send_char(filler(), eager);
      send_char(lsm_pkg::NEWLINE_BYTE, eager);
    end
  endtask

  // Result side. Stretches of steady ready, random ready and short stalls alternate. Every so
  // many cycles the receiver holds off for a long stretch while text keeps coming, so that the
  // single result register fills and the block has to stall its input.
  initial begin
    int n;
    int r;
    int elapsed;
    int hold_at;
    out_ready <= 1'b0;
    elapsed = 0;
    hold_at = 900;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (elapsed >= hold_at) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        elapsed += 300;
        hold_at += 2500;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          n = $urandom_range(5, 60);
          repeat (n) begin
            out_ready <= 1'b1;
            @(posedge clk);
          end
        end else if (r < 85) begin
          n = $urandom_range(10, 50);
          repeat (n) begin
            out_ready <= ($urandom_range(0, 9) < 7);
            @(posedge clk);
          end
        end else begin
          n = (r < 97) ? $urandom_range(1, 4) : $urandom_range(10, 40);
          repeat (n) begin
            out_ready <= 1'b0;
            @(posedge clk);
          end
        end
        elapsed += n;
      end
    end
  end

  initial begin
    int ph;
    in_valid   <= 1'b0;
    in_char_in <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    rst_n      <= 1'b0;
    eff_len     = 1;
    fold_on     = 1'b0;
    phase_items = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings hold a single zero byte as the pattern: an empty line gives nothing,
    // a line with a zero byte is a hit, a line with an all-ones byte is not.
    send_char(lsm_pkg::NEWLINE_BYTE, 1'b0);
    send_char('0, 1'b0);
    send_char(lsm_pkg::NEWLINE_BYTE, 1'b0);
    send_char('1, 1'b0);
    send_char(lsm_pkg::NEWLINE_BYTE, 1'b0);

    // Two-byte pattern with case folding; the text differs in case on both bytes.
    settle();
    pat[0] = "a";
    pat[1] = "Z";
    load_pattern(5'd2, 1'b1, 1'b0);
    send_text("xAz\n");

    // A length of zero behaves as one, and a pattern holding a newline can never match.
    settle();
    pat[0] = lsm_pkg::NEWLINE_BYTE;
    load_pattern(5'd0, 1'b0, 1'b0);
    send_text("q\n");

    // Exact compare rejects a case variant and takes the exact text; a stray register write
    // after the four register writes must change nothing.
    settle();
    pat[0] = "A";
    pat[1] = "b";
    pat[2] = "C";
    load_pattern(5'd3, 1'b0, 1'b1);
    send_text("abc\nAbC\n");

    // Random phases, each with its own settings. The length codes cover one, sixteen, zero and
    // values past sixteen; the all-ones and all-zero patterns fill both pattern words.
    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          make_pattern(PAT_ANY);
          load_pattern(5'd1, 1'b0, 1'b0);
        end
        1: begin
          make_pattern(PAT_LETTERS);
          load_pattern(5'd16, 1'b1, 1'b0);
        end
        2: begin
          make_pattern(PAT_LETTERS);
          load_pattern(5'd0, 1'b0, 1'b0);
        end
        3: begin
          make_pattern(PAT_ONES);
          load_pattern(5'd31, 1'b0, 1'b0);
        end
        4: begin
          make_pattern(PAT_ZEROS);
          load_pattern(5'd16, 1'b0, 1'b0);
        end
        5: begin
          make_pattern(PAT_LETTERS);
          load_pattern(5'd17, 1'b1, 1'b0);
        end
        6: begin
          make_pattern(PAT_LETTERS);
          load_pattern(lsm_pkg::LEN_W'($urandom_range(2, 8)), 1'b1, 1'b1);
        end
        7: begin
          make_pattern(PAT_ANY);
          load_pattern(lsm_pkg::LEN_W'($urandom_range(9, 15)), 1'b0, 1'b0);
        end
        default: begin
          make_pattern(PAT_LETTERS);
          load_pattern(lsm_pkg::LEN_W'($urandom_range(1, 16)), $urandom_range(0, 1) == 1,
                       1'b0);
        end
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) send_line();
    end

    // A last line without its newline must not report anything.
    repeat (3) send_char(filler(), 1'b1);

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("[line_substring_matcher] OK");
    end else begin
      $display("[line_substring_matcher] ERROR");
    end
    $finish;
  end

endmodule
